### src/mux_adc_scan_iir_filter_macros.svh
// assertion macros used by the scanner back end
`ifndef MUX_ADC_SCAN_IIR_FILTER_MACROS_SVH
`define MUX_ADC_SCAN_IIR_FILTER_MACROS_SVH

// checked on every clock edge outside reset
`define MSIF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define MSIF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/msif_pkg.sv
// types and constants of the multiplexed adc scanner with iir smoothing
package msif_pkg;

  localparam int ADC_W    = 16;
  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 6;
  localparam int SHIFT_W  = 4;
  localparam int LIMIT_W  = 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 12'hFFF;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT  = 1'd1;
  localparam logic [SHIFT_W-1:0]   FILTER_SHIFT_RST = 4'd4;
  localparam logic [LIMIT_W-1:0]   STALL_LIMIT_RST  = 8'd10;

  // input function codes
  localparam logic [1:0] FUNC_CONV  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_PRIME = 2'd2;

  // result kinds
  localparam logic KIND_MUX    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_CW    = 2;

  // result queue at the back
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  typedef struct packed {
    logic [1:0]       func;
    logic [ADC_W-1:0] adc_word;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] filtered_value;
    logic [SAMPLE_W-1:0] raw_value;
    logic                restart;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] filter_shift;
    logic [LIMIT_W-1:0] stall_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_CONV,
    OP_TICK,
    OP_PRIME
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_PRIME
  } back_state_t;

endpackage

### src/msif_ram.sv
// generic single write port ram with registered read
module msif_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/msif_front.sv
// front end: accepts input beats, decodes the function and queues commands
module msif_front
  import msif_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  cmd_t               cmdq [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_CW-1:0] count;
  logic               in_take;
  logic               enq;
  logic               deq;
  cmd_t               decoded;
  logic               known;

  assign full      = (count == CMDQ_CW'(CMDQ_DEPTH));
  assign in_take   = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = cmdq[rd_ptr];
  assign deq       = cmd_valid && cmd_ready;
  assign enq       = in_take && known;

  // unused function code is taken and dropped
  always_comb begin
    known          = 1'b1;
    decoded.sample = in_data.adc_word[SAMPLE_W-1:0] & SAMPLE_MASK;
    case (in_data.func)
      FUNC_CONV:  decoded.op = OP_CONV;
      FUNC_TICK:  decoded.op = OP_TICK;
      FUNC_PRIME: decoded.op = OP_PRIME;
      default: begin
        decoded.op = OP_CONV;
        known      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + CMDQ_AW'(1);
      end
      if (deq) begin
        rd_ptr <= rd_ptr + CMDQ_AW'(1);
      end
      count <= count + CMDQ_CW'(enq) - CMDQ_CW'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      cmdq[wr_ptr] <= decoded;
    end
  end

endmodule

### src/msif_back.sv
// back end: channel sequencer, watchdog, sample stores, iir sweep and result queue
`include "mux_adc_scan_iir_filter_macros.svh"

module msif_back
  import msif_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  localparam int IW = $clog2(CHANNELS);
  localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

  back_state_t state;
  back_state_t state_next;

  logic [IW-1:0]      cur_chan;
  logic               scan_done;
  logic [LIMIT_W-1:0] stall_count;
  logic               restart;
  logic [IW-1:0]      idx;
  logic [CHANNELS-1:0] raw_vld;
  logic [CHANNELS-1:0] filt_vld;

  // read stage
  logic          s1_valid;
  logic          s1_tick;
  logic [IW-1:0] s1_idx;
  logic          s1_raw_vld;
  logic          s1_filt_vld;

  logic [SAMPLE_W-1:0] raw_rdata;
  logic [SAMPLE_W-1:0] filt_rdata;
  logic [SAMPLE_W-1:0] raw_x;
  logic [SAMPLE_W-1:0] filt_y;
  logic [SAMPLE_W-1:0] new_y;
  logic signed [SAMPLE_W:0] diff;
  logic signed [SAMPLE_W:0] step;
  logic signed [SAMPLE_W:0] sum;

  // result queue
  out_item_t          outq [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] out_wr;
  logic [OUTQ_AW-1:0] out_rd;
  logic [OUTQ_CW-1:0] out_count;
  logic               out_push;
  logic               out_pop;
  out_item_t          out_new;
  logic               out_room;

  logic               take;
  logic               take_conv;
  logic               take_tick;
  logic               issue;
  logic [IW-1:0]      next_chan;
  logic               wrap;
  logic [LIMIT_W-1:0] stall_inc;

  assign out_room  = (out_count < OUTQ_CW'(OUTQ_DEPTH));
  assign cmd_ready = (state == ST_IDLE) && !s1_valid &&
                     ((cmd.op != OP_CONV) || out_room);
  assign take      = cmd_valid && cmd_ready;
  assign take_conv = take && (cmd.op == OP_CONV);
  assign take_tick = take && (cmd.op == OP_TICK);

  assign wrap      = (cur_chan == LAST_IDX);
  assign next_chan = wrap ? '0 : cur_chan + IW'(1);
  assign stall_inc = stall_count + LIMIT_W'(1);

  // read issue; report sweep keeps a slot for the beat in flight
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (take && cmd.op == OP_TICK) begin
          state_next = ST_TICK;
        end else if (take && cmd.op == OP_PRIME) begin
          state_next = ST_PRIME;
        end
      end
      ST_TICK: begin
        issue = ({1'b0, out_count} + (OUTQ_CW + 1)'(s1_valid)) < (OUTQ_CW + 1)'(OUTQ_DEPTH);
        if (issue && idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_PRIME: begin
        issue = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cur_chan    <= '0;
      scan_done   <= 1'b0;
      stall_count <= '0;
      restart     <= 1'b0;
      idx         <= '0;
      raw_vld     <= '0;
      filt_vld    <= '0;
      s1_valid    <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issue;
      if (take) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + IW'(1);
      end
      if (take_conv) begin
        raw_vld[cur_chan] <= 1'b1;
        cur_chan          <= next_chan;
        if (wrap) begin
          scan_done <= 1'b1;
        end
      end
      // stall watchdog runs once per tick before the sweep
      if (take_tick) begin
        if (scan_done) begin
          scan_done   <= 1'b0;
          stall_count <= '0;
          restart     <= 1'b0;
        end else if (stall_inc >= cfg.stall_limit) begin
          stall_count <= '0;
          cur_chan    <= '0;
          restart     <= 1'b1;
        end else begin
          stall_count <= stall_inc;
          restart     <= 1'b0;
        end
      end
      if (s1_valid) begin
        filt_vld[s1_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_tick     <= (state == ST_TICK);
      s1_idx      <= idx;
      s1_raw_vld  <= raw_vld[idx];
      s1_filt_vld <= filt_vld[idx];
    end
  end

  msif_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (CHANNELS)
  ) u_raw_ram (
    .clk   (clk),
    .we    (take_conv),
    .waddr (cur_chan),
    .wdata (cmd.sample),
    .raddr (idx),
    .rdata (raw_rdata)
  );

  msif_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (CHANNELS)
  ) u_filt_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_idx),
    .wdata (s1_tick ? new_y : raw_x),
    .raddr (idx),
    .rdata (filt_rdata)
  );

  // entries never written since reset read as zero
  assign raw_x  = s1_raw_vld ? raw_rdata : '0;
  assign filt_y = s1_filt_vld ? filt_rdata : '0;

  // y += (x - y) >>> shift, floor rounding
  assign diff  = $signed({1'b0, raw_x}) - $signed({1'b0, filt_y});
  assign step  = diff >>> cfg.filter_shift;
  assign sum   = $signed({1'b0, filt_y}) + step;
  assign new_y = sum[SAMPLE_W-1:0];

  always_comb begin
    out_new = '0;
    if (take_conv) begin
      out_new.kind    = KIND_MUX;
      out_new.channel = CHAN_W'(next_chan);
      out_new.last    = 1'b1;
    end else begin
      out_new.kind           = KIND_REPORT;
      out_new.channel        = CHAN_W'(s1_idx);
      out_new.filtered_value = new_y;
      out_new.raw_value      = raw_x;
      out_new.restart        = restart;
      out_new.last           = (s1_idx == LAST_IDX);
    end
  end

  assign out_push = take_conv || (s1_valid && s1_tick);
  assign empty    = (out_count == '0);
  assign out_pop  = pop && !empty;
  assign out_data = outq[out_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      if (out_push) begin
        out_wr <= out_wr + OUTQ_AW'(1);
      end
      if (out_pop) begin
        out_rd <= out_rd + OUTQ_AW'(1);
      end
      out_count <= out_count + OUTQ_CW'(out_push) - OUTQ_CW'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      outq[out_wr] <= out_new;
    end
  end

  `MSIF_ASSERT(a_outq_no_overflow, (out_push && !out_pop) |-> out_room, "result queue overflow")
  `MSIF_ASSERT_ALWAYS(a_outq_count_range, rst || (out_count <= OUTQ_CW'(OUTQ_DEPTH)), "bad count")
  `MSIF_ASSERT(a_take_only_when_drained, take |-> !s1_valid && state == ST_IDLE, "command taken mid sweep")
  `MSIF_ASSERT(a_sweep_ends_drained, (state != ST_IDLE && state_next == ST_IDLE) |=> s1_valid && !cmd_ready, "sweep tail not drained")

endmodule

### src/mux_adc_scan_iir_filter.sv
// top level of the multiplexed adc scanner with per-channel iir smoothing
//
// usage
//   input channel: a beat is taken on a rising edge with push high and full low;
//     func selects conversion done, filter tick or prime, adc_word carries the
//     converter result (low 12 bits) for a conversion; func code 3 is taken and dropped
//   result channel: while empty is low the oldest result is on out_data; it is
//     taken on a rising edge with pop high
//   config: cfg_write with cfg_index 0 (filter_shift) or 1 (stall_limit), idle only
// timing
//   a conversion writes one mux select beat into the result queue as it is taken
//   a tick walks every channel through one read port of the raw and filtered
//     rams, one channel a cycle while the result queue has room: CHANNELS report beats
//   a prime sweeps the same way without pausing and gives no result
// reset
//   rst clears both queues, the channel pointer and watchdog, and the per-entry
//   valid bits, so both sample stores read as zero until written; no clearing pass
// stalls
//   when pop stays low the result queue fills, the tick sweep pauses, then the
//   two-entry command queue fills and full rises; nothing is dropped
module mux_adc_scan_iir_filter
  import msif_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_data,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_shift <= FILTER_SHIFT_RST;
      cfg.stall_limit  <= STALL_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FILTER_SHIFT: cfg.filter_shift <= cfg_data[SHIFT_W-1:0];
        REG_STALL_LIMIT:  cfg.stall_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // decode and queue input beats
  msif_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // execute commands and queue results
  msif_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

### dv/msif_scoreboard.sv
// scoreboard and behavioral predictor for the multiplexed adc scanner testbench
`timescale 1ns / 1ps
package msif_scoreboard_pkg;
  import msif_pkg::*;

  localparam int SCAN_CHANNELS = 16;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  class scan_scoreboard;
    logic [SAMPLE_W-1:0] raw_level [SCAN_CHANNELS];
    logic [SAMPLE_W-1:0] smooth_level [SCAN_CHANNELS];
    int unsigned         mux_chan;
    bit                  scan_seen;
    logic [LIMIT_W-1:0]  stall_ticks;
    logic [SHIFT_W-1:0]  shift_setting;
    logic [LIMIT_W-1:0]  limit_setting;
    out_item_t           expected_beats[$];
    int unsigned         beats_seen;
    int unsigned         mismatches;

    function new();
      foreach (raw_level[i]) begin
        raw_level[i]    = '0;
        smooth_level[i] = '0;
      end
      mux_chan      = 0;
      scan_seen     = 1'b0;
      stall_ticks   = '0;
      shift_setting = FILTER_SHIFT_RST;
      limit_setting = STALL_LIMIT_RST;
      beats_seen    = 0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FILTER_SHIFT) shift_setting = data[SHIFT_W-1:0];
      else if (idx == REG_STALL_LIMIT) limit_setting = data[LIMIT_W-1:0];
    endfunction

    // y + floor((x - y) / 2^shift), wrapped to the sample width
    function logic [SAMPLE_W-1:0] smooth_step(logic [SAMPLE_W-1:0] y, logic [SAMPLE_W-1:0] x);
      int diff;
      int sum;
      diff = int'(x) - int'(y);
      sum  = int'(y) + (diff >>> shift_setting);
      return sum[SAMPLE_W-1:0];
    endfunction

    function void note_item(in_item_t item);
      out_item_t beat;
      bit        restart;
      beat = '0;
      case (item.func)
        FUNC_CONV: begin
          raw_level[mux_chan] = item.adc_word[SAMPLE_W-1:0] & SAMPLE_MASK;
          mux_chan++;
          if (mux_chan >= SCAN_CHANNELS) begin
            mux_chan  = 0;
            scan_seen = 1'b1;
          end
          beat.kind    = KIND_MUX;
          beat.channel = mux_chan[CHAN_W-1:0];
          beat.last    = 1'b1;
          expected_beats.push_back(beat);
        end
        FUNC_TICK: begin
          restart = 1'b0;
          if (scan_seen) begin
            scan_seen   = 1'b0;
            stall_ticks = '0;
          end else begin
            stall_ticks++;
            if (stall_ticks >= limit_setting) begin
              stall_ticks = '0;
              mux_chan    = 0;
              restart     = 1'b1;
            end
          end
          for (int i = 0; i < SCAN_CHANNELS; i++) begin
            smooth_level[i]     = smooth_step(smooth_level[i], raw_level[i]);
            beat.kind           = KIND_REPORT;
            beat.channel        = i[CHAN_W-1:0];
            beat.filtered_value = smooth_level[i];
            beat.raw_value      = raw_level[i];
            beat.restart        = restart;
            beat.last           = (i == SCAN_CHANNELS - 1);
            expected_beats.push_back(beat);
          end
        end
        FUNC_PRIME: begin
          foreach (smooth_level[i]) smooth_level[i] = raw_level[i];
        end
        default: ;  // unused code is dropped without effect
      endcase
    endfunction

    function int unsigned expected_left();
      return expected_beats.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at result beat %0d: %s", beats_seen, what);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_beat(out_item_t got);
      out_item_t want;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
        return;
      end
      want = expected_beats.pop_front();
      check_field("kind", 16'(got.kind), 16'(want.kind));
      check_field("channel", 16'(got.channel), 16'(want.channel));
      check_field("filtered_value", 16'(got.filtered_value), 16'(want.filtered_value));
      check_field("raw_value", 16'(got.raw_value), 16'(want.raw_value));
      check_field("restart", 16'(got.restart), 16'(want.restart));
      check_field("last", 16'(got.last), 16'(want.last));
    endtask
  endclass

endpackage

### dv/mux_adc_scan_iir_filter_tb.sv
// self-checking testbench for the multiplexed adc scanner with iir smoothing
`timescale 1ns / 1ps
module mux_adc_scan_iir_filter_tb;
  import msif_pkg::*;
  import msif_scoreboard_pkg::*;

  // cycles with no beat moving anywhere before the run is declared hung
  localparam int WATCHDOG_LIMIT = 5000;
  // a prime sweeps every channel with no result, so give it time to finish
  localparam int DRAIN_CYCLES = 2 * SCAN_CHANNELS + 8;
  // long receiver hold-off that backs the block up into full
  localparam int HOLD_CYCLES = 600;

  logic                  clk;
  logic                  rst;
  logic                  push;
  logic                  full;
  in_item_t              in_data;
  logic                  empty;
  logic                  pop;
  out_item_t             out_data;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // per-cycle odds (out of 100) that the sender idles / the receiver stalls
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned quiet_cycles   = 0;

  scan_scoreboard sb = new();

  mux_adc_scan_iir_filter #(
    .CHANNELS(SCAN_CHANNELS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: sample handshakes at the edge, before any driver update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.write_reg(cfg_index, cfg_data);
      if (push && !full) sb.note_item(in_data);
      if (pop && !empty) sb.check_beat(out_data);
    end
  end

  // watchdog: any input beat, result beat or register write resets the count
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off counted here on request
  initial begin : receiver
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t make_item(logic [1:0] f, logic [ADC_W-1:0] word);
    in_item_t it;
    it.func     = f;
    it.adc_word = word;
    return it;
  endfunction

  // mostly conversions and ticks, some primes, a few unused codes
  function automatic logic [1:0] pick_func();
    int r;
    r = $urandom_range(99);
    if (r < 50) return FUNC_CONV;
    if (r < 75) return FUNC_TICK;
    if (r < 90) return FUNC_PRIME;
    return FUNC_UNUSED;
  endfunction

  // offer one input beat and hold it until taken; then maybe idle a while
  task automatic push_item(in_item_t it);
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    if ($urandom_range(99) < send_idle_pct) begin
      // push drops here; idle data is noise the block must not take
      push    <= 1'b0;
      in_data <= make_item(2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)));
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_func(logic [1:0] f, inout int sent);
    push_item(make_item(f, 16'($urandom_range(16'hFFFF))));
    if (f != FUNC_UNUSED) sent++;
  endtask

  // stop offering, let every expected result drain, then let a prime finish
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (sb.expected_left() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // new phase: block idle, both registers rewritten, new idling odds
  task automatic start_phase(logic [CFG_DATA_W-1:0] shift_data,
                             logic [CFG_DATA_W-1:0] limit_data,
                             int send_idle, int recv_stall);
    wait_drained();
    write_config(REG_FILTER_SHIFT, shift_data);
    write_config(REG_STALL_LIMIT, limit_data);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
  endtask

  // random sequences: mostly whole scans ending in a tick, so the scan flag
  // and watchdog clear paths get exercised, mixed with broken partial scans,
  // tick runs that push the watchdog toward a restart, and primes/noise
  task automatic run_random(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          repeat (SCAN_CHANNELS) send_func(FUNC_CONV, sent);
          send_func(FUNC_TICK, sent);
        end
        4, 5, 6: begin
          len = $urandom_range(1, 6);
          repeat (len) send_func(pick_func(), sent);
        end
        7, 8: begin
          len = $urandom_range(1, 4);
          repeat (len) send_func(FUNC_TICK, sent);
        end
        default: begin
          send_func(FUNC_PRIME, sent);
          send_func(FUNC_UNUSED, sent);
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int pressure_sent;
    pressure_sent = 0;
    rst       <= 1'b1;
    push      <= 1'b0;
    in_data   <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset settings (shift 4, stall limit 10)
    // tick on cleared stores
    push_item(make_item(FUNC_TICK, 16'h0000));
    // sample extremes, upper word bits must be masked off
    push_item(make_item(FUNC_CONV, 16'hFFFF));
    push_item(make_item(FUNC_CONV, 16'h0000));
    push_item(make_item(FUNC_CONV, 16'hF123));
    push_item(make_item(FUNC_CONV, 16'h0FFF));
    // positive smoothing steps
    push_item(make_item(FUNC_TICK, 16'h5A5A));
    // prime copies raw into filtered, unused code is ignored
    push_item(make_item(FUNC_PRIME, 16'hFFFF));
    push_item(make_item(FUNC_UNUSED, 16'hFFFF));
    // finish the scan: channel wraps and the scan flag sets
    for (int k = 0; k < SCAN_CHANNELS - 4; k++) begin
      push_item(make_item(FUNC_CONV, k[0] ? 16'hFFFF : 16'h0000));
    end
    // scan seen: watchdog clears
    push_item(make_item(FUNC_TICK, 16'h0000));
    // channel 0 drops to zero below a full filtered level: negative step
    push_item(make_item(FUNC_CONV, 16'h0000));
    push_item(make_item(FUNC_TICK, 16'h0000));

    // zero shift and zero stall limit: each tick without a scan restarts
    start_phase(8'h00, 8'h00, 0, 0);
    push_item(make_item(FUNC_TICK, 16'h0000));
    push_item(make_item(FUNC_CONV, 16'h0ABC));
    push_item(make_item(FUNC_TICK, 16'h0000));

    // random phases across register settings and idling patterns
    start_phase(8'hA0, 8'h01, 0, 0);
    run_random(100);
    start_phase(8'h5F, 8'hFF, 81, 0);
    run_random(100);
    start_phase(8'($urandom_range(255)), 8'h00, 0, 81);
    run_random(100);
    start_phase(8'($urandom_range(255)), 8'($urandom_range(2, 12)), 12, 12);
    run_random(100);

    // backpressure: receiver holds off while ticks keep coming, so the
    // result queue and command queue fill and full must rise
    start_phase(8'h04, 8'h03, 0, 12);
    hold_req = 1'b1;
    while (pressure_sent < 40) begin
      send_func(($urandom_range(3) == 0) ? FUNC_CONV : FUNC_TICK, pressure_sent);
    end

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
